// ===== rtl/anchor_point_placer_assert.svh =====
// Assertion macros for the anchor point placer.
// Used inside modules that have clk and rst_n; no other dependencies.
`ifndef ANCHOR_POINT_PLACER_ASSERT_SVH
`define ANCHOR_POINT_PLACER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define APL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define APL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/apl_pkg.sv =====
// Shared types, constants and ring tables for the anchor point placer.
// No dependencies; used by apl_axis, apl_step and anchor_point_placer.
`default_nettype none

package apl_pkg;

  typedef enum logic [2:0] {
    CMD_CYCLE   = 3'd0,
    CMD_SET     = 3'd1,
    CMD_SNAP    = 3'd2,
    CMD_NUDGE   = 3'd3,
    CMD_COMPUTE = 3'd4,
    CMD_CLEAR   = 3'd5
  } cmd_e_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  localparam logic [3:0]  SLOT_NONE   = 4'd9;
  localparam logic [3:0]  RING_LAST   = 4'd8;
  localparam logic [3:0]  GRID_CELLS  = 4'd9;
  localparam logic [31:0] INSET_LIMIT = 32'd512;

  typedef struct packed {
    cmd_e_t             command;
    logic        [3:0]  grid_pos;
    logic        [1:0]  direction;
    logic signed [31:0] delta_x;
    logic signed [31:0] delta_y;
    logic signed [31:0] rect_x;
    logic signed [31:0] rect_y;
    logic        [30:0] rect_width;
    logic        [30:0] rect_height;
    logic signed [31:0] safe_x;
    logic signed [31:0] safe_y;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic        [3:0]  anchor;
  } result_t;

  // ring order: centre, then clockwise from top-left
  function automatic logic [1:0] ring_col(input logic [3:0] slot);
    logic [1:0] c;
    case (slot)
      4'd0:    c = 2'd1;
      4'd1:    c = 2'd0;
      4'd2:    c = 2'd1;
      4'd3:    c = 2'd2;
      4'd4:    c = 2'd2;
      4'd5:    c = 2'd2;
      4'd6:    c = 2'd1;
      4'd7:    c = 2'd0;
      4'd8:    c = 2'd0;
      default: c = 2'd1;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] ring_row(input logic [3:0] slot);
    logic [1:0] r;
    case (slot)
      4'd0:    r = 2'd1;
      4'd1:    r = 2'd0;
      4'd2:    r = 2'd0;
      4'd3:    r = 2'd0;
      4'd4:    r = 2'd1;
      4'd5:    r = 2'd2;
      4'd6:    r = 2'd2;
      4'd7:    r = 2'd2;
      4'd8:    r = 2'd1;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

  // row-major grid position to ring slot
  function automatic logic [3:0] grid_to_ring(input logic [3:0] pos);
    logic [3:0] s;
    case (pos)
      4'd0:    s = 4'd1;
      4'd1:    s = 4'd2;
      4'd2:    s = 4'd3;
      4'd3:    s = 4'd8;
      4'd4:    s = 4'd0;
      4'd5:    s = 4'd4;
      4'd6:    s = 4'd7;
      4'd7:    s = 4'd6;
      4'd8:    s = 4'd5;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] ring_at(input logic [1:0] col, input logic [1:0] row);
    logic [3:0] idx;
    idx = {row, 2'b00} - {2'b00, row} + {2'b00, col};
    return grid_to_ring(idx);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/apl_axis.sv =====
// One axis of the point computation: inset, cell pick or fallback, nudge add, clamp.
// Depends on apl_pkg.
`default_nettype none

module apl_axis (
  input  wire logic signed [31:0] origin,
  input  wire logic        [30:0] size,
  input  wire logic        [1:0]  pick,
  input  wire logic signed [31:0] offset,
  input  wire logic               use_fallback,
  input  wire logic signed [31:0] fallback,
  output logic signed [31:0]      point
);

  logic        [31:0] span_m1;
  logic               empty;
  logic        [31:0] quarter;
  logic        [31:0] inset;
  logic        [31:0] half;
  logic        [31:0] far_end;
  logic        [31:0] rel;
  logic        [33:0] base;
  logic        [33:0] sum;
  logic               ovf;

  assign span_m1 = {1'b0, size} - 32'd1;
  assign empty   = (size == '0);
  assign quarter = {2'b00, span_m1[31:2]};
  assign inset   = empty ? 32'd0
                 : ((quarter > apl_pkg::INSET_LIMIT) ? apl_pkg::INSET_LIMIT : quarter);
  assign half    = empty ? 32'd0 : {1'b0, span_m1[31:1]};
  assign far_end = span_m1 - inset;

  always_comb begin
    case (pick)
      2'd0:    rel = inset;
      2'd1:    rel = half;
      default: rel = far_end;
    endcase
  end

  assign base = use_fallback ? {{2{fallback[31]}}, fallback}
              : ({{2{origin[31]}}, origin} + {{2{rel[31]}}, rel});
  assign sum  = base + {{2{offset[31]}}, offset};
  assign ovf  = !((sum[33:31] == 3'b000) || (sum[33:31] == 3'b111));

  assign point = ovf ? (sum[33] ? 32'sh8000_0000 : 32'sh7fff_ffff) : sum[31:0];

endmodule

`default_nettype wire

// ===== rtl/apl_step.sv =====
// Command decode and anchor/nudge state; produces one result per word.
// Depends on apl_pkg and apl_axis.
`default_nettype none

module apl_step (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            fire,
  input  wire apl_pkg::item_t  item,
  output apl_pkg::result_t     res
);

  logic        [3:0]  anchor_r, anchor_nxt;
  logic signed [31:0] offset_x_r, offset_x_nxt;
  logic signed [31:0] offset_y_r, offset_y_nxt;
  logic        [1:0]  col, row;
  logic        [1:0]  snap_col, snap_row;
  logic        [32:0] nx, ny;
  logic               no_anchor;
  logic signed [31:0] px, py;
  apl_pkg::status_t   status;

  assign no_anchor = (anchor_r == apl_pkg::SLOT_NONE);
  assign col       = apl_pkg::ring_col(anchor_r);
  assign row       = apl_pkg::ring_row(anchor_r);
  assign nx = {offset_x_r[31], offset_x_r} + {item.delta_x[31], item.delta_x};
  assign ny = {offset_y_r[31], offset_y_r} + {item.delta_y[31], item.delta_y};

  apl_axis u_axis_x (
    .origin       (item.rect_x),
    .size         (item.rect_width),
    .pick         (col),
    .offset       (offset_x_r),
    .use_fallback (no_anchor),
    .fallback     (item.safe_x),
    .point        (px)
  );

  apl_axis u_axis_y (
    .origin       (item.rect_y),
    .size         (item.rect_height),
    .pick         (row),
    .offset       (offset_y_r),
    .use_fallback (no_anchor),
    .fallback     (item.safe_y),
    .point        (py)
  );

  always_comb begin
    anchor_nxt   = anchor_r;
    offset_x_nxt = offset_x_r;
    offset_y_nxt = offset_y_r;
    status       = apl_pkg::ST_OK;
    snap_col     = no_anchor ? 2'd1 : col;
    snap_row     = no_anchor ? 2'd1 : row;
    case (item.command)
      apl_pkg::CMD_CYCLE: begin
        anchor_nxt   = (no_anchor || anchor_r == apl_pkg::RING_LAST) ? 4'd0 : anchor_r + 4'd1;
        offset_x_nxt = '0;
        offset_y_nxt = '0;
      end
      apl_pkg::CMD_SET: begin
        if (item.grid_pos >= apl_pkg::GRID_CELLS) begin
          status = apl_pkg::ST_INVALID;
        end else begin
          anchor_nxt   = apl_pkg::grid_to_ring(item.grid_pos);
          offset_x_nxt = '0;
          offset_y_nxt = '0;
        end
      end
      apl_pkg::CMD_SNAP: begin
        case (apl_pkg::dir_t'(item.direction))
          apl_pkg::DIR_LEFT:  snap_col = 2'd0;
          apl_pkg::DIR_RIGHT: snap_col = 2'd2;
          apl_pkg::DIR_UP:    snap_row = 2'd0;
          default:            snap_row = 2'd2;
        endcase
        anchor_nxt   = apl_pkg::ring_at(snap_col, snap_row);
        offset_x_nxt = '0;
        offset_y_nxt = '0;
      end
      apl_pkg::CMD_NUDGE: begin
        if (item.delta_x == '0 && item.delta_y == '0) begin
          status = apl_pkg::ST_INVALID;
        end else if ((nx[32] != nx[31]) || (ny[32] != ny[31])) begin
          status = apl_pkg::ST_OVERFLOW;
        end else begin
          offset_x_nxt = nx[31:0];
          offset_y_nxt = ny[31:0];
        end
      end
      apl_pkg::CMD_COMPUTE: begin
        status = apl_pkg::ST_OK;
      end
      apl_pkg::CMD_CLEAR: begin
        anchor_nxt   = apl_pkg::SLOT_NONE;
        offset_x_nxt = '0;
        offset_y_nxt = '0;
      end
      default: begin
        status = apl_pkg::ST_INVALID;
      end
    endcase
  end

  always_comb begin
    res.status  = status;
    res.point_x = (item.command == apl_pkg::CMD_COMPUTE) ? px : 32'sd0;
    res.point_y = (item.command == apl_pkg::CMD_COMPUTE) ? py : 32'sd0;
    res.anchor  = anchor_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anchor_r   <= apl_pkg::SLOT_NONE;
      offset_x_r <= '0;
      offset_y_r <= '0;
    end else if (fire) begin
      anchor_r   <= anchor_nxt;
      offset_x_r <= offset_x_nxt;
      offset_y_r <= offset_y_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/anchor_point_placer.sv =====
// Anchor point placer: input register, command step, result register.
// Depends on apl_pkg, apl_step (and apl_axis), anchor_point_placer_assert.svh.
//
// Usage:
//   Input channel in_*: one command word per handshake; in_tuser carries the
//   command code, in_tdata the arguments. Output channel out_*: exactly one
//   result word per command, in order; out_tuser carries the status.
//   A word accepted is held in the input register, then its result is
//   registered on out_*. Throughput: one word per cycle while out_tready holds;
//   state from one command is seen by the very next one.
//   The rate is set by the single step stage between the input register and
//   the result register, which also updates the anchor and nudge state.
//   Reset (rst_n low, synchronous): both stages empty, anchor none, nudge 0.
//   Receiver stall: the result is held on out_*; if the input register is empty,
//   one more word is taken into it, then in_tready drops until out_tready returns.
`default_nettype none

module anchor_point_placer (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // grid_pos[3:0] direction[5:4] delta_x[37:6] delta_y[69:38] rect_x[101:70]
  // rect_y[133:102] rect_width[164:134] rect_height[195:165] safe_x[227:196]
  // safe_y[259:228], zero pad [263:260]
  input  wire logic [263:0] in_tdata,
  // command[2:0]
  input  wire logic [2:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // point_x[31:0] point_y[63:32] anchor[67:64], zero pad [71:68]
  output logic [71:0]       out_tdata,
  // status[1:0]
  output logic [1:0]        out_tuser
);

  logic             in_v_r;
  logic             out_v_r;
  apl_pkg::item_t   item_r, item_nxt;
  apl_pkg::result_t res_r, res_nxt;
  logic             adv;
  logic             fire;
  logic             res_fail;
  logic             point_zero;
  logic             clear_fire;
  logic             clear_seen;

  assign adv       = !out_v_r || out_tready;
  assign fire      = in_v_r && adv;
  assign in_tready = !in_v_r || adv;

  always_comb begin
    item_nxt.command     = apl_pkg::cmd_e_t'(in_tuser);
    item_nxt.grid_pos    = in_tdata[3:0];
    item_nxt.direction   = in_tdata[5:4];
    item_nxt.delta_x     = in_tdata[37:6];
    item_nxt.delta_y     = in_tdata[69:38];
    item_nxt.rect_x      = in_tdata[101:70];
    item_nxt.rect_y      = in_tdata[133:102];
    item_nxt.rect_width  = in_tdata[164:134];
    item_nxt.rect_height = in_tdata[195:165];
    item_nxt.safe_x      = in_tdata[227:196];
    item_nxt.safe_y      = in_tdata[259:228];
  end

  apl_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .res   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (adv) begin
        out_v_r <= in_v_r;
      end
    end
    if (in_tready && in_tvalid) begin
      item_r <= item_nxt;
    end
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'b0000, res_r.anchor, res_r.point_y, res_r.point_x};
  assign out_tuser  = res_r.status;

  assign res_fail   = out_v_r && (res_r.status != apl_pkg::ST_OK);
  assign point_zero = (res_r.point_x == '0) && (res_r.point_y == '0);
  assign clear_fire = fire && (item_r.command == apl_pkg::CMD_CLEAR);
  assign clear_seen = out_v_r && (res_r.anchor == apl_pkg::SLOT_NONE)
                   && (res_r.status == apl_pkg::ST_OK);

`include "anchor_point_placer_assert.svh"

  `APL_ASSERT_IMP(a_anchor_range, out_v_r, res_r.anchor <= apl_pkg::SLOT_NONE, "anchor range")
  `APL_ASSERT_IMP(a_point_zero, res_fail, point_zero, "point set on failed command")
  `APL_ASSERT_IMP(a_stall_full, !in_tready, in_v_r && out_v_r, "input stalled with free stage")
  `APL_ASSERT_NXT(a_clear, clear_fire, clear_seen, "clear did not drop anchor")

endmodule

`default_nettype wire
